// ===== sv/task_wait_queue_priority_unit_defines.svh =====
// Assertion macros shared by the checker
`ifndef TASK_WAIT_QUEUE_PRIORITY_UNIT_DEFINES_SVH
`define TASK_WAIT_QUEUE_PRIORITY_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define TWQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define TWQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/twqp_pkg.sv =====
// Package: types, constants and op codes for the task wait queue unit
`default_nettype none
package twqp_pkg;
    localparam int TASK_SLOTS  = 32;
    localparam int QUEUE_COUNT = 8;
    localparam int PRIO_BITS   = 8;
    localparam int TW = 5;
    localparam int QW = 3;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] queue_id;
        logic [4:0] task_id;
        logic [7:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic [4:0] head_task;
        logic       queue_empty;
        logic [1:0] status;
    } out_item_t;

    // slot memory write/read request
    typedef struct packed {
        logic          rd;
        logic [TW-1:0] raddr;
        logic          wn;
        logic          wp;
        logic          wpr;
        logic [TW-1:0] waddr;
        logic [TW-1:0] nxt;
        logic [TW-1:0] prv;
        logic [PRIO_BITS-1:0] pri;
    } mem_req_t;

    typedef struct packed {
        logic [TW-1:0] nxt;
        logic [TW-1:0] prv;
        logic [PRIO_BITS-1:0] pri;
    } slot_t;
endpackage
`default_nettype wire

// ===== sv/twqp_slot_mem.sv =====
// Slot link memory: next, prev and priority per task, registered read
`default_nettype none
module twqp_slot_mem (
    input  wire logic              clk,
    input  wire twqp_pkg::mem_req_t req,
    output twqp_pkg::slot_t        rdata
);
    import twqp_pkg::*;
    logic [TW-1:0]        nxt_mem [TASK_SLOTS];
    logic [TW-1:0]        prv_mem [TASK_SLOTS];
    logic [PRIO_BITS-1:0] pri_mem [TASK_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.wn)
            nxt_mem[req.waddr] <= req.nxt;
        if (req.wp)
            prv_mem[req.waddr] <= req.prv;
        if (req.wpr)
            pri_mem[req.waddr] <= req.pri;
        if (req.rd)
        begin
            rdata.nxt <= nxt_mem[req.raddr];
            rdata.prv <= prv_mem[req.raddr];
            rdata.pri <= pri_mem[req.raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/task_wait_queue_priority_unit.sv =====
// Top level: priority-ordered task wait queues over a linked slot memory
//
//  channel | signals            | payload
//  in      | in_valid, in_stall | in_item  (op, queue_id, task_id, priority_req)
//  out     | out_valid,out_stall| out_item (head_task, queue_empty, status)
//
// One item at a time: a new beat is taken only once the last op has finished. A
// priority insert compares tasks one by one from the tail toward the head, and
// takes an extra read of the head when the new task becomes the head.
// Each memory read returns its data from a register.
// Reset clears membership and head valid flags; link memory is not cleared.
// The result sits in an output register; a new beat is taken only once it has
// been accepted downstream.
`default_nettype none
module task_wait_queue_priority_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire twqp_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output twqp_pkg::out_item_t     out_item
);
    import twqp_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD1  = 10'b0000000010, // issue read of first slot
        S_A1   = 10'b0000000100, // have slot data 1
        S_RD2  = 10'b0000001000,
        S_A2   = 10'b0000010000,
        S_WALK = 10'b0000100000, // issue read of scan slot
        S_CMP  = 10'b0001000000,
        S_FIX  = 10'b0010000000, // second link write
        S_RPT  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [TW-1:0] ta_reg, ta_next;   // scratch slot A
    logic [TW-1:0] tb_reg, tb_next;   // scratch slot B
    logic [TW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] rq_reg, rq_next;   // reported queue
    logic [1:0]    st_reg, st_next;
    logic [TW-1:0] head_reg [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] hv_reg;
    logic [QW-1:0] mq_reg [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] mv_reg;
    out_item_t out_reg;
    logic out_valid_reg;

    mem_req_t req;
    slot_t rd;

    twqp_slot_mem u_mem (.clk(clk), .req(req), .rdata(rd));

    logic [TW-1:0] t;
    logic [QW-1:0] q;
    logic [TW-1:0] hq;
    logic [PRIO_BITS-1:0] pr;
    assign t  = item_reg.task_id;
    assign q  = item_reg.queue_id;
    assign hq = head_reg[q];
    assign pr = item_reg.priority_req[PRIO_BITS-1:0];

    // head/membership updates
    logic          hw;
    logic [QW-1:0] hw_q;
    logic [TW-1:0] hw_d;
    logic          hv_set, hv_clr;
    logic          mv_set, mv_clr;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next    = state_reg;
        ta_next       = ta_reg;
        tb_next       = tb_reg;
        cnt_next      = cnt_reg;
        rq_next       = rq_reg;
        st_next       = st_reg;
        req           = '0;
        hw = 1'b0; hw_q = q; hw_d = '0;
        hv_set = 1'b0; hv_clr = 1'b0; mv_set = 1'b0; mv_clr = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                    state_next = S_RD1;
            end
            S_RD1:
            begin
                rq_next = q;
                st_next = ST_DONE;
                state_next = S_RPT;
                case (item_reg.op)
                    OP_ROTATE:
                    begin
                        if (!hv_reg[q])
                            st_next = ST_NONE;
                        else
                        begin
                            req.rd = 1'b1; req.raddr = hq;
                            state_next = S_A1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!mv_reg[t])
                            st_next = ST_NONE;
                        else
                        begin
                            rq_next = mq_reg[t];
                            req.rd = 1'b1; req.raddr = t;
                            state_next = S_A1;
                        end
                    end
                    default:
                    begin
                        if (mv_reg[t])
                            st_next = ST_QUEUED;
                        else
                        begin
                            mv_set = 1'b1;
                            req.wpr = 1'b1; req.waddr = t; req.pri = pr;
                            if (!hv_reg[q])
                            begin
                                hw = 1'b1; hw_d = t; hv_set = 1'b1;
                                req.wn = 1'b1; req.wp = 1'b1;
                                req.nxt = t; req.prv = t;
                            end
                            else
                            begin
                                req.rd = 1'b1; req.raddr = hq;
                                state_next = S_A1;
                            end
                        end
                    end
                endcase
            end
            S_A1:
            begin
                state_next = S_RPT;
                case (item_reg.op)
                    OP_ROTATE:
                    begin
                        hw = 1'b1; hw_d = rd.nxt;
                    end
                    OP_REMOVE:
                    begin
                        mv_clr = 1'b1;
                        if (rd.nxt == t)
                        begin
                            hw_q = rq_reg; hv_clr = 1'b1;
                        end
                        else
                        begin
                            if (head_reg[rq_reg] == t)
                            begin
                                hw = 1'b1; hw_q = rq_reg; hw_d = rd.nxt;
                            end
                            ta_next = rd.nxt; tb_next = rd.prv;
                            req.wp = 1'b1; req.waddr = rd.nxt; req.prv = rd.prv;
                            state_next = S_FIX;
                        end
                    end
                    OP_APPEND:
                    begin
                        // t between tail (rd.prv) and head
                        req.wn = 1'b1; req.wp = 1'b1; req.waddr = t;
                        req.nxt = hq; req.prv = rd.prv;
                        ta_next = hq; tb_next = rd.prv;
                        state_next = S_FIX;
                    end
                    default:
                    begin
                        ta_next = rd.prv; // scan slot c
                        cnt_next = '0;
                        req.rd = 1'b1; req.raddr = rd.prv;
                        state_next = S_CMP;
                    end
                endcase
            end
            S_WALK:
            begin
                req.rd = 1'b1; req.raddr = ta_reg;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd.pri <= pr)
                begin
                    // insert between c and next(c)
                    req.wn = 1'b1; req.wp = 1'b1; req.waddr = t;
                    req.nxt = rd.nxt; req.prv = ta_reg;
                    tb_next = ta_reg; ta_next = rd.nxt;
                    state_next = S_FIX;
                end
                else if (ta_reg == hq || cnt_reg == TW'(TASK_SLOTS - 1))
                begin
                    req.rd = 1'b1; req.raddr = hq;
                    state_next = S_RD2;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    ta_next = rd.prv;
                    state_next = S_WALK;
                end
            end
            S_RD2:
            begin
                // new head: t between tail and old head
                req.wn = 1'b1; req.wp = 1'b1; req.waddr = t;
                req.nxt = hq; req.prv = rd.prv;
                ta_next = hq; tb_next = rd.prv;
                hw = 1'b1; hw_d = t;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                // ta/tb: next and prev neighbours
                state_next = S_A2;
                if (item_reg.op == OP_REMOVE)
                begin
                    req.wn = 1'b1; req.waddr = tb_reg; req.nxt = ta_reg;
                    state_next = S_RPT;
                end
                else
                begin
                    req.wp = 1'b1; req.waddr = ta_reg; req.prv = t;
                end
            end
            S_A2:
            begin
                req.wn = 1'b1; req.waddr = tb_reg; req.nxt = t;
                state_next = S_RPT;
            end
            S_RPT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hv_reg        <= '0;
            mv_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++)
                mq_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (hv_set) hv_reg[hw_q] <= 1'b1;
            if (hv_clr) hv_reg[hw_q] <= 1'b0;
            if (mv_set)
            begin
                mv_reg[t] <= 1'b1;
                mq_reg[t] <= q;
            end
            if (mv_clr) mv_reg[t] <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_item;
        ta_reg <= ta_next;
        tb_reg <= tb_next;
        cnt_reg <= cnt_next;
        rq_reg <= rq_next;
        st_reg <= st_next;
        if (hw)
            head_reg[hw_q] <= hw_d;
        if (state_reg == S_RPT)
        begin
            out_reg.status <= st_reg;
            if (hv_reg[rq_reg])
            begin
                out_reg.head_task   <= head_reg[rq_reg];
                out_reg.queue_empty <= 1'b0;
            end
            else
            begin
                out_reg.head_task   <= '0;
                out_reg.queue_empty <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/twqp_checker.sv =====
// Port-level checker for the task wait queue unit, with bind
`default_nettype none
`include "task_wait_queue_priority_unit_defines.svh"
module twqp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire twqp_pkg::out_item_t out_item
);
    import twqp_pkg::*;
    `TWQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, $stable(out_item), "held result changed")
    `TWQ_ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, in_stall, "input taken while result waits")
    `TWQ_ASSERT_NXT(a_one_in, clk, rst_n, in_valid && !in_stall, in_stall, "two beats back to back")
    `TWQ_ASSERT_IMP(a_empty_head, clk, rst_n, out_valid && out_item.queue_empty, out_item.head_task == '0, "empty queue with head")
    `TWQ_ASSERT_IMP(a_status, clk, rst_n, out_valid, out_item.status != 2'd3, "bad status")
endmodule

bind task_wait_queue_priority_unit twqp_checker u_twqp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire
